/* rtl/skf_pkg.sv */
package skf_pkg;

   localparam int DEF_MAX_COLS = 1024;
   localparam int DEF_MAX_ROWS = 1024;

   localparam int GEOM_LAT   = 5;
   localparam int DIV_LAT    = 31;
   localparam int DECAY_LAT  = 14;
   localparam int GRAD_LAT   = 7;
   localparam int PIPE_LAT   = GEOM_LAT + DIV_LAT + GRAD_LAT;
   localparam int SPEC_DEPTH = GEOM_LAT + DIV_LAT;
   localparam int E_DEPTH    = DIV_LAT - DECAY_LAT;

   localparam logic [62:0] SAT_LIM   = 63'h4000_0000_0000_0000;
   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [31:0] LN2_Q32   = 32'd2977044472;

   typedef enum logic [2:0] {
      CSR_WAVE_SCALE_X = 3'd0,
      CSR_WAVE_SCALE_Y = 3'd1,
      CSR_GRID_COLS    = 3'd2,
      CSR_GRID_ROWS    = 3'd3,
      CSR_DECAY_FACTOR = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] a_re;
      logic signed [31:0] a_im;
      logic signed [32:0] s_re;
      logic signed [32:0] s_im;
      logic signed [31:0] d_re;
      logic signed [31:0] d_im;
   } spec_type;

   typedef struct packed {
      logic [10:0] u1;
      logic [10:0] u2;
      logic        n1;
      logic        n2;
      logic        zero;
   } bin_type;

   typedef struct packed {
      logic signed [31:0] gx_re;
      logic signed [31:0] gx_im;
      logic signed [31:0] gy_re;
      logic signed [31:0] gy_im;
   } res_type;

   function automatic logic [31:0] pow2_neg(input logic [2:0] idx);
      logic [31:0] val;
      unique case (idx)
         3'd0: val = 32'd3037000500;
         3'd1: val = 32'd3611622603;
         3'd2: val = 32'd3938502376;
         3'd3: val = 32'd4112874773;
         3'd4: val = 32'd4202935003;
         3'd5: val = 32'd4248701965;
         3'd6: val = 32'd4271771996;
         default: val = 32'd4283353945;
      endcase
      return val;
   endfunction

endpackage

/* rtl/stresslet_pressure_grad_kspace_filter.sv */
// An accepted item passes the geometry, divider and gradient stages, then the output register drives rsp_valid.
// Throughput: one item per cycle while req_ready is high; the depth is set mostly by the 31-step weight divider.
// A two-entry output buffer lets the pipeline keep accepting while a result waits.
// Reset clears the pipeline and output buffer and loads the register defaults
// (wave scales 1.0, 1024 columns and rows, zero decay).
module stresslet_pressure_grad_kspace_filter #(
   parameter int MAX_COLS = skf_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = skf_pkg::DEF_MAX_ROWS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [9:0]         req_col_index,
   input  logic [9:0]         req_row_index,
   input  logic signed [31:0] req_a_re,
   input  logic signed [31:0] req_a_im,
   input  logic signed [31:0] req_b_re,
   input  logic signed [31:0] req_b_im,
   input  logic signed [31:0] req_c_re,
   input  logic signed [31:0] req_c_im,
   input  logic signed [31:0] req_d_re,
   input  logic signed [31:0] req_d_im,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_grad_x_re,
   output logic signed [31:0] rsp_grad_x_im,
   output logic signed [31:0] rsp_grad_y_re,
   output logic signed [31:0] rsp_grad_y_im,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   logic [31:0] wave_scale_x_ff, wave_scale_x_in;
   logic [31:0] wave_scale_y_ff, wave_scale_y_in;
   logic [10:0] grid_cols_ff, grid_cols_in;
   logic [10:0] grid_rows_ff, grid_rows_in;
   logic [31:0] decay_factor_ff, decay_factor_in;

   logic adv;
   logic push;
   logic rsp_free;

   logic               v_ff    [skf_pkg::PIPE_LAT];
   skf_pkg::spec_type  spec_in;
   skf_pkg::spec_type  spec_ff [skf_pkg::SPEC_DEPTH];
   skf_pkg::bin_type   bin_geo;
   skf_pkg::bin_type   bin_ff  [skf_pkg::DIV_LAT];
   logic [30:0]        e_dec;
   logic [30:0]        e_ff    [skf_pkg::E_DEPTH];

   logic [61:0] q11, q22, q12;
   logic [62:0] sn, ksq;
   logic [30:0] w11, w22, w12;

   skf_pkg::res_type res;
   skf_pkg::res_type rsp_data_ff, rsp_data_in, skid_data_ff, skid_data_in;
   logic             rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;

   always_comb begin
      wave_scale_x_in = wave_scale_x_ff;
      wave_scale_y_in = wave_scale_y_ff;
      grid_cols_in    = grid_cols_ff;
      grid_rows_in    = grid_rows_ff;
      decay_factor_in = decay_factor_ff;
      if (csr_we) begin
         unique case (csr_index)
            skf_pkg::CSR_WAVE_SCALE_X: wave_scale_x_in = csr_wdata;
            skf_pkg::CSR_WAVE_SCALE_Y: wave_scale_y_in = csr_wdata;
            skf_pkg::CSR_GRID_COLS:    grid_cols_in    = csr_wdata[10:0];
            skf_pkg::CSR_GRID_ROWS:    grid_rows_in    = csr_wdata[10:0];
            skf_pkg::CSR_DECAY_FACTOR: decay_factor_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_scale_x_ff <= 32'd65536;
         wave_scale_y_ff <= 32'd65536;
         grid_cols_ff    <= 11'd1024;
         grid_rows_ff    <= 11'd1024;
         decay_factor_ff <= '0;
      end else begin
         wave_scale_x_ff <= wave_scale_x_in;
         wave_scale_y_ff <= wave_scale_y_in;
         grid_cols_ff    <= grid_cols_in;
         grid_rows_ff    <= grid_rows_in;
         decay_factor_ff <= decay_factor_in;
      end
   end

   assign adv       = !skid_valid_ff;
   assign req_ready = adv;
   assign push      = adv && v_ff[skf_pkg::PIPE_LAT-1];

   always_comb begin
      spec_in.a_re = req_a_re;
      spec_in.a_im = req_a_im;
      spec_in.s_re = 33'(req_b_re) + 33'(req_c_re);
      spec_in.s_im = 33'(req_b_im) + 33'(req_c_im);
      spec_in.d_re = req_d_re;
      spec_in.d_im = req_d_im;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < skf_pkg::PIPE_LAT; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         v_ff[0] <= req_valid;
         for (int i = 1; i < skf_pkg::PIPE_LAT; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         spec_ff[0] <= spec_in;
         for (int i = 1; i < skf_pkg::SPEC_DEPTH; i++) begin
            spec_ff[i] <= spec_ff[i-1];
         end
         bin_ff[0] <= bin_geo;
         for (int i = 1; i < skf_pkg::DIV_LAT; i++) begin
            bin_ff[i] <= bin_ff[i-1];
         end
         e_ff[0] <= e_dec;
         for (int i = 1; i < skf_pkg::E_DEPTH; i++) begin
            e_ff[i] <= e_ff[i-1];
         end
      end
   end

   skf_geom #(
      .MAX_COLS(MAX_COLS),
      .MAX_ROWS(MAX_ROWS)
   ) u_geom (
      .clock        (clock),
      .adv          (adv),
      .col_index    (req_col_index),
      .row_index    (req_row_index),
      .grid_cols    (grid_cols_ff),
      .grid_rows    (grid_rows_ff),
      .wave_scale_x (wave_scale_x_ff),
      .wave_scale_y (wave_scale_y_ff),
      .q11          (q11),
      .q22          (q22),
      .q12          (q12),
      .sn           (sn),
      .ksq          (ksq),
      .bin          (bin_geo)
   );

   skf_div u_div11 (.clock(clock), .adv(adv), .num(q11), .den(sn), .quot(w11));
   skf_div u_div22 (.clock(clock), .adv(adv), .num(q22), .den(sn), .quot(w22));
   skf_div u_div12 (.clock(clock), .adv(adv), .num(q12), .den(sn), .quot(w12));

   skf_decay u_decay (
      .clock        (clock),
      .adv          (adv),
      .ksq          (ksq),
      .decay_factor (decay_factor_ff),
      .e            (e_dec)
   );

   skf_grad u_grad (
      .clock        (clock),
      .adv          (adv),
      .w11          (w11),
      .w22          (w22),
      .w12          (w12),
      .e            (e_ff[skf_pkg::E_DEPTH-1]),
      .spec         (spec_ff[skf_pkg::SPEC_DEPTH-1]),
      .bin          (bin_ff[skf_pkg::DIV_LAT-1]),
      .wave_scale_x (wave_scale_x_ff),
      .wave_scale_y (wave_scale_y_ff),
      .res          (res)
   );

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = push;
            rsp_data_in  = res;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_grad_x_re = rsp_data_ff.gx_re;
   assign rsp_grad_x_im = rsp_data_ff.gx_im;
   assign rsp_grad_y_re = rsp_data_ff.gy_re;
   assign rsp_grad_y_im = rsp_data_ff.gy_im;

endmodule

/* rtl/skf_geom.sv */
module skf_geom #(
   parameter int MAX_COLS = skf_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = skf_pkg::DEF_MAX_ROWS
) (
   input  logic              clock,
   input  logic              adv,
   input  logic [9:0]        col_index,
   input  logic [9:0]        row_index,
   input  logic [10:0]       grid_cols,
   input  logic [10:0]       grid_rows,
   input  logic [31:0]       wave_scale_x,
   input  logic [31:0]       wave_scale_y,
   output logic [61:0]       q11,
   output logic [61:0]       q22,
   output logic [61:0]       q12,
   output logic [62:0]       sn,
   output logic [62:0]       ksq,
   output skf_pkg::bin_type  bin
);

   localparam logic [31:0] LIM_C = 32'(MAX_COLS);
   localparam logic [31:0] LIM_R = 32'(MAX_ROWS);

   function automatic logic [11:0] wrap(input logic [9:0] idx, input logic [10:0] grid,
                                        input logic [31:0] lim);
      logic [10:0]        eff;
      logic signed [11:0] diff;
      logic [11:0]        res;
      eff = grid;
      if (grid < 11'd2) begin
         eff = 11'd2;
      end else if ({21'd0, grid} > lim) begin
         eff = lim[10:0];
      end
      diff = $signed({2'b00, idx}) - $signed({1'b0, eff});
      if (idx <= eff[10:1]) begin
         res = {2'b00, idx};
      end else if (diff < 0) begin
         res = {1'b1, 11'(-diff)};
      end else begin
         res = {1'b0, diff[10:0]};
      end
      return res;
   endfunction

   skf_pkg::bin_type bin_ff [skf_pkg::GEOM_LAT];
   skf_pkg::bin_type bin0_in, bin2_in;
   logic [11:0] w1, w2;

   logic [42:0] big1_ff, big2_ff;
   logic [42:0] maxk;
   logic [3:0]  sh;
   logic [30:0] k1n_in, k2n_in, k1n_ff, k2n_ff;
   logic [30:0] lo1_ff, lo2_ff;
   logic        hi1_ff, hi2_ff;
   logic [61:0] q11_ff, q22_ff, q12_ff;
   logic [62:0] t1_in, t2_in, t1_ff, t2_ff;
   logic [61:0] q11o_ff, q22o_ff, q12o_ff;
   logic [62:0] sn_ff, ksq_ff, ksq_in;
   logic [63:0] ks;

   always_comb begin
      w1 = wrap(col_index, grid_cols, LIM_C);
      w2 = wrap(row_index, grid_rows, LIM_R);
      bin0_in.u1   = w1[10:0];
      bin0_in.n1   = w1[11];
      bin0_in.u2   = w2[10:0];
      bin0_in.n2   = w2[11];
      bin0_in.zero = 1'b0;
   end

   always_comb begin
      bin2_in      = bin_ff[1];
      bin2_in.zero = (big1_ff == '0) && (big2_ff == '0);
      maxk = (big1_ff > big2_ff) ? big1_ff : big2_ff;
      sh   = '0;
      for (int i = 31; i < 43; i++) begin
         if (maxk[i]) begin
            sh = 4'(i - 30);
         end
      end
      k1n_in = 31'(big1_ff >> sh);
      k2n_in = 31'(big2_ff >> sh);
   end

   always_comb begin
      t1_in = hi1_ff ? skf_pkg::SAT_LIM : 63'(62'(lo1_ff) * 62'(lo1_ff));
      t2_in = hi2_ff ? skf_pkg::SAT_LIM : 63'(62'(lo2_ff) * 62'(lo2_ff));
      ks     = 64'(t1_ff) + 64'(t2_ff);
      ksq_in = (ks > 64'(skf_pkg::SAT_LIM)) ? skf_pkg::SAT_LIM : ks[62:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bin_ff[0] <= bin0_in;
         bin_ff[1] <= bin_ff[0];
         bin_ff[2] <= bin2_in;
         bin_ff[3] <= bin_ff[2];
         bin_ff[4] <= bin_ff[3];
         big1_ff   <= 43'(bin_ff[0].u1) * 43'(wave_scale_x);
         big2_ff   <= 43'(bin_ff[0].u2) * 43'(wave_scale_y);
         k1n_ff    <= k1n_in;
         k2n_ff    <= k2n_in;
         hi1_ff    <= |big1_ff[42:31];
         hi2_ff    <= |big2_ff[42:31];
         lo1_ff    <= big1_ff[30:0];
         lo2_ff    <= big2_ff[30:0];
         q11_ff    <= 62'(k1n_ff) * 62'(k1n_ff);
         q22_ff    <= 62'(k2n_ff) * 62'(k2n_ff);
         q12_ff    <= 62'(k1n_ff) * 62'(k2n_ff);
         t1_ff     <= t1_in;
         t2_ff     <= t2_in;
         q11o_ff   <= q11_ff;
         q22o_ff   <= q22_ff;
         q12o_ff   <= q12_ff;
         sn_ff     <= 63'(q11_ff) + 63'(q22_ff);
         ksq_ff    <= ksq_in;
      end
   end

   assign q11 = q11o_ff;
   assign q22 = q22o_ff;
   assign q12 = q12o_ff;
   assign sn  = sn_ff;
   assign ksq = ksq_ff;
   assign bin = bin_ff[4];

endmodule

/* rtl/skf_div.sv */
module skf_div (
   input  logic        clock,
   input  logic        adv,
   input  logic [61:0] num,
   input  logic [62:0] den,
   output logic [30:0] quot
);

   logic [62:0] rem_ff [skf_pkg::DIV_LAT];
   logic [62:0] den_ff [skf_pkg::DIV_LAT];
   logic [30:0] quo_ff [skf_pkg::DIV_LAT];
   logic [62:0] rem_in [skf_pkg::DIV_LAT];
   logic [30:0] quo_in [skf_pkg::DIV_LAT];
   logic [62:0] den_in [skf_pkg::DIV_LAT];
   logic [63:0] cur    [skf_pkg::DIV_LAT];
   logic [30:0] base   [skf_pkg::DIV_LAT];

   always_comb begin
      for (int i = 0; i < skf_pkg::DIV_LAT; i++) begin
         if (i == 0) begin
            cur[i]    = 64'(num);
            base[i]   = '0;
            den_in[i] = den;
         end else begin
            cur[i]    = {rem_ff[i-1], 1'b0};
            base[i]   = {quo_ff[i-1][29:0], 1'b0};
            den_in[i] = den_ff[i-1];
         end
         if (cur[i] >= 64'(den_in[i])) begin
            rem_in[i] = 63'(cur[i] - 64'(den_in[i]));
            quo_in[i] = base[i] | 31'd1;
         end else begin
            rem_in[i] = cur[i][62:0];
            quo_in[i] = base[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < skf_pkg::DIV_LAT; i++) begin
            rem_ff[i] <= rem_in[i];
            quo_ff[i] <= quo_in[i];
            den_ff[i] <= den_in[i];
         end
      end
   end

   assign quot = quo_ff[skf_pkg::DIV_LAT-1];

endmodule

/* rtl/skf_decay.sv */
module skf_decay (
   input  logic        clock,
   input  logic        adv,
   input  logic [62:0] ksq,
   input  logic [31:0] decay_factor,
   output logic [30:0] e
);

   typedef struct packed {
      logic        sat;
      logic [6:0]  n;
      logic [7:0]  fbits;
      logic [32:0] factor;
      logic [30:0] acc;
   } exp_type;

   logic [62:0] ph_ff;
   logic [63:0] pl_ff;
   logic [94:0] sum;
   logic        sat2_ff, sat3_ff;
   logic [21:0] x_ff;
   logic [38:0] y_ff;
   exp_type     st_ff [9];
   exp_type     st_in [9];
   logic [55:0] rl;
   logic [30:0] acc13_ff;
   logic        sat13_ff;
   logic [6:0]  n13_ff;
   logic [30:0] e_ff, e_in;

   always_comb begin
      sum = {ph_ff, 32'd0} + 95'(pl_ff);
      rl  = 56'(y_ff[23:0]) * 56'(skf_pkg::LN2_Q32);
      st_in[0].sat    = sat3_ff;
      st_in[0].n      = y_ff[38:32];
      st_in[0].fbits  = y_ff[31:24];
      st_in[0].factor = 33'h1_0000_0000 - 33'(rl >> 32);
      st_in[0].acc    = 31'h4000_0000;
      for (int j = 0; j < 8; j++) begin
         st_in[j+1] = st_ff[j];
         if (st_ff[j].fbits[7-j]) begin
            st_in[j+1].acc = 31'((63'(st_ff[j].acc) * 63'(skf_pkg::pow2_neg(3'(j)))) >> 32);
         end
      end
      if (sat13_ff || n13_ff >= 7'd31) begin
         e_in = '0;
      end else begin
         e_in = acc13_ff >> n13_ff[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ph_ff    <= 63'(ksq[62:32]) * 63'(decay_factor);
         pl_ff    <= 64'(ksq[31:0]) * 64'(decay_factor);
         sat2_ff  <= |sum[94:62];
         x_ff     <= sum[61:40];
         sat3_ff  <= sat2_ff;
         y_ff     <= 39'((53'(x_ff) * 53'(skf_pkg::LOG2E_Q30)) >> 14);
         for (int j = 0; j < 9; j++) begin
            st_ff[j] <= st_in[j];
         end
         acc13_ff <= 31'((65'(st_ff[8].acc) * 65'(st_ff[8].factor)) >> 32);
         sat13_ff <= st_ff[8].sat;
         n13_ff   <= st_ff[8].n;
         e_ff     <= e_in;
      end
   end

   assign e = e_ff;

endmodule

/* rtl/skf_grad.sv */
module skf_grad (
   input  logic              clock,
   input  logic              adv,
   input  logic [30:0]       w11,
   input  logic [30:0]       w22,
   input  logic [30:0]       w12,
   input  logic [30:0]       e,
   input  skf_pkg::spec_type spec,
   input  skf_pkg::bin_type  bin,
   input  logic [31:0]       wave_scale_x,
   input  logic [31:0]       wave_scale_y,
   output skf_pkg::res_type  res
);

   logic signed [63:0] p11_ff [2];
   logic signed [64:0] p12_ff [2];
   logic signed [63:0] p22_ff [2];
   logic signed [65:0] sum    [2];
   logic signed [33:0] g_ff   [2];
   logic signed [65:0] prod   [2];
   logic signed [33:0] ge_ff  [2];
   logic               wneg_ff;
   logic [30:0]        e1_ff, e2_ff;
   skf_pkg::bin_type   bin_ff [3];

   logic signed [33:0] lge    [4];
   logic [10:0]        lu     [4];
   logic               ln     [4];
   logic [32:0]        gabs   [4];
   logic [43:0]        a_in   [4];
   logic               neg_in [4];
   logic [43:0]        a_ff   [4];
   logic               neg4_ff [4];
   logic               neg5_ff [4];
   logic               neg6_ff [4];
   logic               zero_ff [3];
   logic [31:0]        lscale [4];
   logic [53:0]        phi_ff [4];
   logic [53:0]        plo_ff [4];
   logic [75:0]        big    [4];
   logic [46:0]        mag_in [4];
   logic [46:0]        mag_ff [4];
   logic [31:0]        out_in [4];
   logic [31:0]        out_ff [4];

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         sum[k]  = 66'(p11_ff[k]) + (wneg_ff ? -66'(p12_ff[k]) : 66'(p12_ff[k]))
                   + 66'(p22_ff[k]);
         prod[k] = g_ff[k] * $signed({1'b0, e2_ff});
      end
      for (int l = 0; l < 4; l++) begin
         lge[l]    = (l % 2 == 0) ? ge_ff[1] : ge_ff[0];
         lu[l]     = (l < 2) ? bin_ff[2].u1 : bin_ff[2].u2;
         ln[l]     = (l < 2) ? bin_ff[2].n1 : bin_ff[2].n2;
         lscale[l] = (l < 2) ? wave_scale_x : wave_scale_y;
         gabs[l]   = lge[l][33] ? 33'(-lge[l]) : 33'(lge[l]);
         a_in[l]   = 44'(gabs[l]) * 44'(lu[l]);
         neg_in[l] = (lge[l][33] != ln[l]) != (l % 2 == 1);
         big[l]    = {phi_ff[l], 22'd0} + 76'(plo_ff[l]);
         mag_in[l] = 47'(((big[l] > 76'(skf_pkg::SAT_LIM)) ? 76'(skf_pkg::SAT_LIM)
                                                            : big[l]) >> 16);
         if (zero_ff[2] || mag_ff[l] == '0) begin
            out_in[l] = '0;
         end else if (!neg6_ff[l]) begin
            out_in[l] = (mag_ff[l] > 47'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag_ff[l][31:0];
         end else if (mag_ff[l] > 47'h8000_0000) begin
            out_in[l] = 32'h8000_0000;
         end else begin
            out_in[l] = 32'd0 - mag_ff[l][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p11_ff[0] <= $signed({1'b0, w11}) * $signed(spec.a_re);
         p11_ff[1] <= $signed({1'b0, w11}) * $signed(spec.a_im);
         p12_ff[0] <= $signed({1'b0, w12}) * $signed(spec.s_re);
         p12_ff[1] <= $signed({1'b0, w12}) * $signed(spec.s_im);
         p22_ff[0] <= $signed({1'b0, w22}) * $signed(spec.d_re);
         p22_ff[1] <= $signed({1'b0, w22}) * $signed(spec.d_im);
         wneg_ff   <= bin.n1 != bin.n2;
         e1_ff     <= e;
         e2_ff     <= e1_ff;
         bin_ff[0] <= bin;
         bin_ff[1] <= bin_ff[0];
         bin_ff[2] <= bin_ff[1];
         for (int k = 0; k < 2; k++) begin
            g_ff[k]  <= sum[k][63:30];
            ge_ff[k] <= prod[k][63:30];
         end
         zero_ff[0] <= bin_ff[2].zero;
         zero_ff[1] <= zero_ff[0];
         zero_ff[2] <= zero_ff[1];
         for (int l = 0; l < 4; l++) begin
            a_ff[l]    <= a_in[l];
            neg4_ff[l] <= neg_in[l];
            phi_ff[l]  <= 54'(a_ff[l][43:22]) * 54'(lscale[l]);
            plo_ff[l]  <= 54'(a_ff[l][21:0]) * 54'(lscale[l]);
            neg5_ff[l] <= neg4_ff[l];
            mag_ff[l]  <= mag_in[l];
            neg6_ff[l] <= neg5_ff[l];
            out_ff[l]  <= out_in[l];
         end
      end
   end

   assign res.gx_re = out_ff[0];
   assign res.gx_im = out_ff[1];
   assign res.gy_re = out_ff[2];
   assign res.gy_im = out_ff[3];

endmodule

/* verif/stresslet_pressure_grad_kspace_filter_tb.sv */
module stresslet_pressure_grad_kspace_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          MAX_COLS   = 1024;
   localparam int          MAX_ROWS   = 1024;
   localparam int          DRAIN_WAIT = 60;
   localparam int          CYCLE_CAP  = 400000;
   localparam logic [63:0] SAT64      = 64'h4000_0000_0000_0000;

   typedef struct {
      logic [9:0]         col;
      logic [9:0]         row;
      logic signed [31:0] a_re, a_im, b_re, b_im, c_re, c_im, d_re, d_im;
   } bin_req_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [9:0]         req_col_index = '0;
   logic [9:0]         req_row_index = '0;
   logic signed [31:0] req_a_re = '0, req_a_im = '0, req_b_re = '0, req_b_im = '0;
   logic signed [31:0] req_c_re = '0, req_c_im = '0, req_d_re = '0, req_d_im = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_grad_x_re, rsp_grad_x_im, rsp_grad_y_re, rsp_grad_y_im;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = skf_pkg::CSR_WAVE_SCALE_X;
   logic [31:0]        csr_wdata = '0;

   logic [31:0] scale_x, scale_y, decay;
   logic [10:0] cols, rows;

   skf_pkg::res_type expected_grads[$];
   int      failures = 0;
   int      burst_left = 0;
   int      hold_left = 0;
   bit      rsp_choppy = 1'b0;
   int      cycles = 0;

   stresslet_pressure_grad_kspace_filter uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [63:0] sat_mul(logic [63:0] a, logic [63:0] b);
      logic [63:0] p;
      if (a == 0 || b == 0) return 0;
      if (b > SAT64 / a) return SAT64;
      p = a * b;
      return (p > SAT64) ? SAT64 : p;
   endfunction

   function automatic logic [63:0] mag_of(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint wrap_bin(logic [9:0] idx, logic [10:0] n, int maxn);
      int lim;
      lim = (n < 2) ? 2 : ((n > maxn) ? maxn : int'(n));
      if (int'(idx) <= lim / 2) return longint'(idx);
      return longint'(idx) - lim;
   endfunction

   function automatic longint weight_q30(logic [63:0] num, logic [63:0] den);
      logic [63:0] q, rem;
      q = 0;
      rem = num;
      if (rem >= den) begin
         q = 1;
         rem -= den;
      end
      for (int i = 0; i < 30; i++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= den) begin
            rem -= den;
            q |= 1;
         end
      end
      return longint'(q);
   endfunction

   function automatic longint decay_q30(logic [63:0] y);
      logic [31:0] tab [8] = '{32'd3037000500, 32'd3611622603, 32'd3938502376,
                               32'd4112874773, 32'd4202935003, 32'd4248701965,
                               32'd4271771996, 32'd4283353945};
      logic [63:0] n, f, acc, r, fac;
      n = y >> 32;
      f = y & 64'hFFFF_FFFF;
      acc = 64'd1 << 30;
      for (int i = 0; i < 8; i++)
         if (f[31-i]) acc = (acc * 64'(tab[i])) >> 32;
      r = f & 64'hFF_FFFF;
      fac = 64'h1_0000_0000 - ((r * 64'(skf_pkg::LN2_Q32)) >> 32);
      acc = (acc * fac) >> 32;
      if (n >= 31) return 0;
      return longint'(acc >> n);
   endfunction

   function automatic logic [31:0] grad_part(longint g, longint m, logic [63:0] sc, bit neg_in);
      bit          neg;
      logic [63:0] mag;
      neg = ((g < 0) != (m < 0)) != neg_in;
      mag = sat_mul(sat_mul(mag_of(g), mag_of(m)), sc) >> 16;
      if (mag == 0) return 0;
      if (!neg) return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      if (mag > 64'h8000_0000) return 32'h8000_0000;
      return 32'(64'h1_0000_0000 - mag);
   endfunction

   function automatic skf_pkg::res_type predict_grads(bin_req_type b);
      skf_pkg::res_type r;
      longint      m1, m2, w11, w22, w12, e, ar, ai, sr, si, dr, di, gr, gi, er, ei;
      logic [63:0] u1, u2, sx, sy, big1, big2, maxk, k1n, k2n, q11, q22, q12, sn;
      logic [63:0] ksq, prod, x;
      int          sh;
      m1 = wrap_bin(b.col, cols, MAX_COLS);
      m2 = wrap_bin(b.row, rows, MAX_ROWS);
      u1 = mag_of(m1);
      u2 = mag_of(m2);
      sx = 64'(scale_x);
      sy = 64'(scale_y);
      big1 = u1 * sx;
      big2 = u2 * sy;
      r = '0;
      if (big1 == 0 && big2 == 0) return r;
      maxk = (big1 > big2) ? big1 : big2;
      sh = 0;
      while ((maxk >> sh) >= 64'h8000_0000) sh++;
      k1n = big1 >> sh;
      k2n = big2 >> sh;
      q11 = k1n * k1n;
      q22 = k2n * k2n;
      q12 = k1n * k2n;
      sn = q11 + q22;
      w11 = weight_q30(q11, sn);
      w22 = weight_q30(q22, sn);
      w12 = weight_q30(q12, sn);
      if ((m1 < 0) != (m2 < 0)) w12 = -w12;
      ksq = sat_mul(u1 * u1, sx * sx) + sat_mul(u2 * u2, sy * sy);
      if (ksq > SAT64) ksq = SAT64;
      prod = sat_mul(ksq, 64'(decay));
      if (prod >= SAT64) begin
         e = 0;
      end else begin
         x = prod >> 40;
         e = decay_q30((x * 64'(skf_pkg::LOG2E_Q30)) >> 14);
      end
      ar = b.a_re;
      ai = b.a_im;
      sr = longint'(b.b_re) + longint'(b.c_re);
      si = longint'(b.b_im) + longint'(b.c_im);
      dr = b.d_re;
      di = b.d_im;
      gr = (w11 * ar + w12 * sr + w22 * dr) >>> 30;
      gi = (w11 * ai + w12 * si + w22 * di) >>> 30;
      er = (gr * e) >>> 30;
      ei = (gi * e) >>> 30;
      r.gx_re = grad_part(ei, m1, sx, 1'b0);
      r.gx_im = grad_part(er, m1, sx, 1'b1);
      r.gy_re = grad_part(ei, m2, sy, 1'b0);
      r.gy_im = grad_part(er, m2, sy, 1'b1);
      return r;
   endfunction

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= rsp_choppy ? ($urandom_range(0, 3) != 0) : 1'b1;
      end
   end

   always @(posedge clock) begin
      skf_pkg::res_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_grads.size() == 0) begin
            $error("unexpected item on the result channel");
            failures++;
         end else begin
            want = expected_grads.pop_front();
            if (rsp_grad_x_re !== want.gx_re) begin
               $error("grad_x_re expected %0d actual %0d", want.gx_re, rsp_grad_x_re);
               failures++;
            end
            if (rsp_grad_x_im !== want.gx_im) begin
               $error("grad_x_im expected %0d actual %0d", want.gx_im, rsp_grad_x_im);
               failures++;
            end
            if (rsp_grad_y_re !== want.gy_re) begin
               $error("grad_y_re expected %0d actual %0d", want.gy_re, rsp_grad_y_re);
               failures++;
            end
            if (rsp_grad_y_im !== want.gy_im) begin
               $error("grad_y_im expected %0d actual %0d", want.gy_im, rsp_grad_y_im);
               failures++;
            end
         end
      end
   end

   task automatic send_bin(bin_req_type b);
      req_valid     <= 1'b1;
      req_col_index <= b.col;
      req_row_index <= b.row;
      req_a_re <= b.a_re;
      req_a_im <= b.a_im;
      req_b_re <= b.b_re;
      req_b_im <= b.b_im;
      req_c_re <= b.c_re;
      req_c_im <= b.c_im;
      req_d_re <= b.d_re;
      req_d_im <= b.d_im;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_grads.push_back(predict_grads(b));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_grads.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(skf_pkg::csr_index_type idx, logic [31:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         skf_pkg::CSR_WAVE_SCALE_X: scale_x = v;
         skf_pkg::CSR_WAVE_SCALE_Y: scale_y = v;
         skf_pkg::CSR_GRID_COLS:    cols = v[10:0];
         skf_pkg::CSR_GRID_ROWS:    rows = v[10:0];
         skf_pkg::CSR_DECAY_FACTOR: decay = v;
         default: ;
      endcase
   endtask

   task automatic set_grid(logic [31:0] sx, logic [31:0] sy, logic [31:0] nc,
                           logic [31:0] nr, logic [31:0] dk);
      csr_write(skf_pkg::CSR_WAVE_SCALE_X, sx);
      csr_write(skf_pkg::CSR_WAVE_SCALE_Y, sy);
      csr_write(skf_pkg::CSR_GRID_COLS, nc);
      csr_write(skf_pkg::CSR_GRID_ROWS, nr);
      csr_write(skf_pkg::CSR_DECAY_FACTOR, dk);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic bin_req_type rand_bin();
      bin_req_type b;
      b.col = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 8)) : 10'($urandom);
      b.row = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 8)) : 10'($urandom);
      b.a_re = rand_word(); b.a_im = rand_word();
      b.b_re = rand_word(); b.b_im = rand_word();
      b.c_re = rand_word(); b.c_im = rand_word();
      b.d_re = rand_word(); b.d_im = rand_word();
      return b;
   endfunction

   function automatic bin_req_type fill_bin(logic [9:0] c, logic [9:0] r, logic [31:0] v);
      bin_req_type b;
      b.col = c;
      b.row = r;
      b.a_re = v; b.a_im = ~v; b.b_re = v; b.b_im = ~v;
      b.c_re = v; b.c_im = ~v; b.d_re = v; b.d_im = ~v;
      return b;
   endfunction

   function automatic logic [31:0] rand_scale();
      case ($urandom_range(0, 5))
         0: return 32'd1;
         1: return 32'hFFFF_FFFF;
         2: return 32'd0;
         default: return $urandom >> $urandom_range(4, 16);
      endcase
   endfunction

   function automatic logic [31:0] rand_decay();
      case ($urandom_range(0, 4))
         0: return 32'd0;
         1: return $urandom;
         default: return $urandom >> $urandom_range(4, 31);
      endcase
   endfunction

   task automatic test_directed();
      logic [9:0] idx [8] = '{10'd0, 10'd1, 10'd511, 10'd512, 10'd513, 10'd1023, 10'd3, 10'd1000};
      send_bin(fill_bin(10'd0, 10'd0, 32'h7FFF_FFFF));
      for (int i = 1; i < 8; i++) begin
         send_bin(fill_bin(idx[i], 10'd0, 32'h8000_0000));
         send_bin(fill_bin(10'd0, idx[i], 32'h7FFF_FFFF));
         send_bin(fill_bin(idx[i], idx[8 - i], 32'h0001_0000));
      end
      settle();
   endtask

   task automatic test_config_extremes();
      logic [31:0] setups [8][5] = '{
         '{32'd1, 32'd1, 32'd2, 32'd2, 32'd0},
         '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1024, 32'd1024, 32'hFFFF_FFFF},
         '{32'd0, 32'd65536, 32'd7, 32'd9, 32'h0100_0000},
         '{32'd65536, 32'd0, 32'd0, 32'd2047, 32'h0000_1000},
         '{32'd411775, 32'd205887, 32'd64, 32'd33, 32'h0010_0000},
         '{32'd65536, 32'd65536, 32'd1, 32'd1025, 32'h0004_0000},
         '{32'h8000_0000, 32'd3, 32'd1023, 32'd16, 32'd1},
         '{32'd65536, 32'd65536, 32'd1024, 32'd1024, 32'd0}};
      for (int s = 0; s < 8; s++) begin
         set_grid(setups[s][0], setups[s][1], setups[s][2], setups[s][3], setups[s][4]);
         rsp_choppy = (s % 2 == 1);
         repeat (30) send_bin(rand_bin());
         settle();
      end
   endtask

   task automatic test_backpressure();
      rsp_choppy = 1'b0;
      hold_left = 400;
      burst_left = 200;
      repeat (120) send_bin(rand_bin());
      settle();
   endtask

   task automatic test_random_streams();
      logic [31:0] nc, nr;
      for (int p = 0; p < 5; p++) begin
         nc = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 2047) : $urandom_range(2, 1024);
         nr = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 2047) : 2 * $urandom_range(1, 512);
         set_grid(rand_scale(), rand_scale(), nc, nr, rand_decay());
         rsp_choppy = $urandom_range(0, 1);
         repeat (40) send_bin(rand_bin());
         settle();
      end
   endtask

   initial begin
      scale_x = 32'd65536;
      scale_y = 32'd65536;
      cols = 11'd1024;
      rows = 11'd1024;
      decay = 32'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_extremes();
      test_backpressure();
      test_random_streams();
      if (failures == 0 && expected_grads.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/skf_pkg.sv
rtl/skf_geom.sv
rtl/skf_div.sv
rtl/skf_decay.sv
rtl/skf_grad.sv
rtl/stresslet_pressure_grad_kspace_filter.sv
verif/stresslet_pressure_grad_kspace_filter_tb.sv
